FILE: sv/huffman_tree_decoder_assert.svh
// Assertion macros for the Huffman tree-walk decoder.
// Included by the top level only; no dependencies beyond clk and arst_n in scope.
`ifndef HUFFMAN_TREE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_ASSERT_SVH
`ifndef SYNTH
`define HTD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HTD_ASSERT_SAME(lbl, ante, cons, msg)
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/htd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
// Used by htd_ctrl, htd_dpath and huffman_tree_decoder; no dependencies.
package htd_pkg;

	localparam int IDX_W     = 9;
	localparam int SYM_W     = 8;
	localparam int DATA_W    = 32;
	localparam int BYTE_BITS = 8;
	localparam int BITCNT_W  = 3;
	localparam int ADDR_W    = 3;

	localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(BYTE_BITS - 1);

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic REG_SYM_LIMIT = 1'b0;
	localparam logic REG_ROOT_NODE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WALK,
		ST_END,
		ST_FLUSH
	} htd_state_t;

	typedef struct packed {
		logic load;
		logic take_byte;
		logic fetch;
		logic step;
		logic fin_eval;
		logic flush;
	} htd_cmd_t;

	typedef struct packed {
		logic out_free;
		logic leaf_hit;
		logic done_hit;
		logic exhausted;
	} htd_sts_t;

endpackage

FILE: sv/htd_ctrl.sv
// Sequencer of the Huffman tree-walk decoder: item handshake and per-bit walk control.
// Depends on htd_pkg; drives htd_dpath through htd_cmd_t.
module htd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             mode,
	input  htd_pkg::htd_sts_t sts,
	output logic             item_stall,
	output htd_pkg::htd_cmd_t cmd
);
	import htd_pkg::*;

	htd_state_t state_q, state_d;
	logic [BITCNT_W-1:0] bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.fetch) begin
				bit_q <= '0;
			end else if (cmd.step) begin
				bit_q <= bit_q + BITCNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && mode == MODE_DECODE && !sts.exhausted) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_WALK;
			ST_WALK: begin
				if (sts.out_free) begin
					if (sts.done_hit) begin
						state_d = ST_FLUSH;
					end else if (bit_q == LAST_BIT) begin
						state_d = ST_END;
					end
				end
			end
			ST_END: begin
				if (sts.out_free) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall    = (state_q != ST_IDLE);
		cmd.load      = (state_q == ST_IDLE) && item_valid && mode == MODE_LOAD;
		cmd.take_byte = (state_q == ST_IDLE) && item_valid && mode == MODE_DECODE;
		cmd.fetch     = (state_q == ST_FETCH);
		cmd.step      = (state_q == ST_WALK) && sts.out_free;
		cmd.fin_eval  = (state_q == ST_END) && sts.out_free;
		cmd.flush     = (state_q == ST_FLUSH) && sts.out_free;
	end

endmodule

FILE: sv/htd_dpath.sv
// Datapath of the Huffman tree-walk decoder: node table, walk registers, counters,
// configuration registers and the result register. Depends on htd_pkg.
module htd_dpath #(
	parameter int NODE_COUNT = 512
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  htd_pkg::htd_cmd_t          cmd,
	output htd_pkg::htd_sts_t          sts,
	input  logic [htd_pkg::IDX_W-1:0]  node_index,
	input  logic                       node_is_leaf,
	input  logic [htd_pkg::IDX_W-1:0]  left_child,
	input  logic [htd_pkg::IDX_W-1:0]  right_child,
	input  logic [htd_pkg::SYM_W-1:0]  leaf_symbol,
	input  logic [htd_pkg::SYM_W-1:0]  coded_byte,
	input  logic                       cfg_we,
	input  logic                       cfg_sel,
	input  logic [htd_pkg::DATA_W-1:0] cfg_wdata,
	output logic [htd_pkg::DATA_W-1:0] cfg_rdata,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [htd_pkg::SYM_W-1:0]  symbol,
	output logic                       last,
	output logic                       finished
);
	import htd_pkg::*;

	localparam int IW    = $clog2(NODE_COUNT);
	localparam int RED_W = IDX_W + 8;
	localparam logic [RED_W-1:0] NC_EXT = RED_W'(NODE_COUNT);

	typedef struct packed {
		logic              leaf;
		logic [IW-1:0]     left;
		logic [IW-1:0]     right;
		logic [SYM_W-1:0]  sym;
	} entry_t;

	function automatic logic [IW-1:0] wrap_idx(input logic [IDX_W-1:0] v);
		logic [RED_W-1:0] r;
		r = RED_W'(v);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (NC_EXT << k)) begin
				r = r - (NC_EXT << k);
			end
		end
		return r[IW-1:0];
	endfunction

	entry_t mem [NODE_COUNT];
	entry_t rd_q, root_rd_q, base;
	logic [IW-1:0] node_q, cur_node_q, root_q, rd_addr, next_idx;
	logic [DATA_W-1:0] size_q, count_q, count_inc;
	logic [SYM_W-1:0] byte_q;
	logic eval_q;
	logic pend_v_q, pend_fin_q;
	logic [SYM_W-1:0] pend_sym_q;
	logic out_v_q, last_q, fin_q;
	logic [SYM_W-1:0] sym_q;
	logic leaf_hit, new_fin, evaluate, push_old, push_flush;

	assign count_inc  = count_q + DATA_W'(1);
	assign leaf_hit   = eval_q && rd_q.leaf;
	assign new_fin    = (count_inc == size_q);
	assign evaluate   = (cmd.step || cmd.fin_eval) && leaf_hit;
	assign push_old   = evaluate && pend_v_q;
	assign push_flush = cmd.flush && pend_v_q;

	assign base     = leaf_hit ? root_rd_q : rd_q;
	assign next_idx = byte_q[SYM_W-1] ? base.right : base.left;
	assign rd_addr  = cmd.fetch ? cur_node_q : next_idx;

	assign sts.out_free  = !out_v_q || !result_stall;
	assign sts.leaf_hit  = leaf_hit;
	assign sts.done_hit  = leaf_hit && new_fin;
	assign sts.exhausted = (count_q == size_q);

	assign cfg_rdata = (cfg_sel == REG_ROOT_NODE) ? DATA_W'(root_q) : size_q;

	// node table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[wrap_idx(node_index)] <= '{leaf: node_is_leaf, left: wrap_idx(left_child),
				right: wrap_idx(right_child), sym: leaf_symbol};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch || cmd.step) begin
			rd_q <= mem[rd_addr];
		end
		root_rd_q <= mem[root_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			byte_q <= coded_byte;
		end else if (cmd.step) begin
			byte_q <= {byte_q[SYM_W-2:0], 1'b0};
		end
		if (cmd.fetch) begin
			node_q <= cur_node_q;
		end else if (cmd.step) begin
			node_q <= next_idx;
		end
		if (evaluate) begin
			pend_sym_q <= rd_q.sym;
			pend_fin_q <= new_fin;
		end
		if (push_old) begin
			sym_q  <= pend_sym_q;
			last_q <= 1'b0;
			fin_q  <= pend_fin_q;
		end else if (push_flush) begin
			sym_q  <= pend_sym_q;
			last_q <= 1'b1;
			fin_q  <= pend_fin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= '0;
			root_q     <= '0;
			cur_node_q <= '0;
			count_q    <= '0;
			eval_q     <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_we && cfg_sel == REG_SYM_LIMIT) begin
				size_q     <= cfg_wdata;
				count_q    <= '0;
				cur_node_q <= root_q;
			end else if (cfg_we && cfg_sel == REG_ROOT_NODE) begin
				root_q     <= wrap_idx(cfg_wdata[IDX_W-1:0]);
				cur_node_q <= wrap_idx(cfg_wdata[IDX_W-1:0]);
			end else begin
				if (evaluate) begin
					count_q <= count_inc;
				end
				if (cmd.fin_eval) begin
					cur_node_q <= leaf_hit ? root_q : node_q;
				end
			end
			if (cmd.fetch) begin
				eval_q <= 1'b0;
			end else if (cmd.step) begin
				eval_q <= 1'b1;
			end
			if (evaluate) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (push_old || push_flush) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_v_q;
	assign symbol       = sym_q;
	assign last         = last_q;
	assign finished     = fin_q;

endmodule

FILE: sv/huffman_tree_decoder.sv
// Huffman tree-walk decoder, top level.
// Items enter on item_valid/item_stall; results leave on result_valid/result_stall.
// mode 0 writes one node of the node table in the cycle the beat is taken; the
// next item can be taken in the cycle after.
// mode 1 decodes one coded byte, most significant bit first: a fetch state
// for the current node, then one walk step per bit (each bit is one dependent read
// of the node table), an evaluate state and a flush state; item_stall holds off
// the next byte until the flush is done, and the walk goes straight to the flush
// when the symbol limit is reached mid-byte.
// Each decoded symbol waits in a one-deep holding register until the next leaf
// of the byte or the flush cycle, then moves to the output register; the last
// symbol of a byte moves there at the flush.
// last marks the final symbol of a byte, finished the symbol that reaches the
// symbol limit. Bytes taken once the limit is reached give nothing.
// While result_stall holds a full output register the walk halts in place.
// Registers on the APB port: symbol limit at 0x0 (write restarts the count and
// the walk), root_node at 0x4. Reset clears both registers, the count and the
// walk; the node table holds garbage until loaded.
// Depends on htd_pkg, htd_ctrl, htd_dpath and huffman_tree_decoder_assert.svh.
module huffman_tree_decoder #(
	parameter int NODE_COUNT = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        mode,
	input  logic [htd_pkg::IDX_W-1:0]   node_index,
	input  logic                        node_is_leaf,
	input  logic [htd_pkg::IDX_W-1:0]   left_child,
	input  logic [htd_pkg::IDX_W-1:0]   right_child,
	input  logic [htd_pkg::SYM_W-1:0]   leaf_symbol,
	input  logic [htd_pkg::SYM_W-1:0]   coded_byte,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [htd_pkg::SYM_W-1:0]   symbol,
	output logic                        last,
	output logic                        finished,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [htd_pkg::ADDR_W-1:0]  paddr,
	input  logic [htd_pkg::DATA_W-1:0]  pwdata,
	output logic [htd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import htd_pkg::*;

	htd_cmd_t cmd;
	htd_sts_t sts;
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	htd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.mode       (mode),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	htd_dpath #(
		.NODE_COUNT (NODE_COUNT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.node_index   (node_index),
		.node_is_leaf (node_is_leaf),
		.left_child   (left_child),
		.right_child  (right_child),
		.leaf_symbol  (leaf_symbol),
		.coded_byte   (coded_byte),
		.cfg_we       (cfg_we),
		.cfg_sel      (paddr[2]),
		.cfg_wdata    (pwdata),
		.cfg_rdata    (prdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.symbol       (symbol),
		.last         (last),
		.finished     (finished)
	);

`include "huffman_tree_decoder_assert.svh"

	`HTD_ASSERT_NEXT(a_stop_after_done, cmd.step && sts.done_hit, !cmd.step, "step after limit")
	`HTD_ASSERT_NEXT(a_skip_exhausted, cmd.take_byte && sts.exhausted, !cmd.fetch, "byte past limit")
	`HTD_ASSERT_SAME(a_finished_is_last, result_valid && finished, last, "finished without last")

endmodule
